// ===== rtl/bitmap_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_macros
// Assertion macros shared by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define BBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bitmap_block_allocator: assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define BBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bitmap_block_allocator: assertion failed");

`endif

// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Constants, types and helpers shared by the bitmap block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    localparam int BLOCK_COUNT   = 1024;
    localparam int BLK_W         = 10;
    localparam int BLOCK_SPAN    = 1 << BLK_W;
    localparam int USABLE_BLOCKS = (BLOCK_COUNT < BLOCK_SPAN) ? BLOCK_COUNT : BLOCK_SPAN;
    localparam int FREE_W        = $clog2(USABLE_BLOCKS + 1);
    localparam int FREE_OUT_W    = 11;

    localparam int BIT_W         = 5;
    localparam int WORD_BITS     = 1 << BIT_W;
    localparam int WORDS         = (USABLE_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W        = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam int KIND_W        = 2;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 24;

    localparam logic [KIND_W-1:0] KIND_ALLOCATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARK     = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [ADDR_W-1:0]    t_addr;

    typedef struct packed {
        logic load;
        logic rd;
        logic upd;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

    // bits of a map word that name a usable block
    function automatic t_word word_mask(input t_addr widx);
        t_word m;
        m = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            m[b] = ((int'(widx) * WORD_BITS + b) < USABLE_BLOCKS);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: take a beat, read the map word, update and post result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl
    import bba_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_UPD;
            end
            ST_UPD: begin
                if (!i_sts.out_busy) begin
                    o_cmd.upd = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp
// Used-map words, per-word full summary, free counter and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_dp
    import bba_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  wire [KIND_W-1:0]     i_kind,
    input  wire [BLK_W-1:0]      i_block,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [M_TDATA_W-1:0] o_out_data
);

    t_word               r_mem [WORDS];
    logic [WORDS-1:0]    r_row_vld;
    logic [WORDS-1:0]    r_full;
    logic [FREE_W-1:0]   r_free;

    logic [KIND_W-1:0]   r_kind;
    logic [BLK_W-1:0]    r_block;
    t_word               r_rd_raw;
    logic                r_rd_vld;
    t_addr               r_widx;
    logic                r_none;

    logic                r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    t_addr               first_open;
    t_addr               rd_addr;
    t_word               word;
    t_word               new_word;
    logic [BIT_W-1:0]    bit_sel;
    logic [BIT_W-1:0]    zero_bit;
    logic                in_range;
    logic                wr_en;
    logic                dec;
    logic                inc;
    logic                status;
    logic [BLK_W-1:0]    granted;
    logic [FREE_W-1:0]   free_next;

    always_comb begin
        first_open = '0;
        for (int i = WORDS - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                first_open = ADDR_W'(i);
            end
        end
    end

    assign rd_addr = (r_kind == KIND_ALLOCATE) ? first_open
                                               : ADDR_W'(r_block[BLK_W-1:BIT_W]);

    assign word     = (r_rd_vld ? r_rd_raw : '0) | ~word_mask(r_widx);
    assign bit_sel  = r_block[BIT_W-1:0];
    assign in_range = ({1'b0, r_block} < (BLK_W + 1)'(USABLE_BLOCKS));

    always_comb begin
        zero_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!word[b]) begin
                zero_bit = BIT_W'(b);
            end
        end
    end

    always_comb begin
        wr_en    = 1'b0;
        dec      = 1'b0;
        inc      = 1'b0;
        status   = STATUS_OK;
        granted  = '0;
        new_word = word;
        case (r_kind)
            KIND_ALLOCATE: begin
                if (r_none) begin
                    status = STATUS_FULL;
                end else begin
                    wr_en              = 1'b1;
                    dec                = 1'b1;
                    new_word[zero_bit] = 1'b1;
                    granted            = BLK_W'({r_widx, zero_bit});
                end
            end
            KIND_RELEASE: begin
                if (in_range && word[bit_sel]) begin
                    wr_en             = 1'b1;
                    inc               = 1'b1;
                    new_word[bit_sel] = 1'b0;
                end
            end
            KIND_MARK: begin
                if (in_range && !word[bit_sel]) begin
                    wr_en             = 1'b1;
                    dec               = 1'b1;
                    new_word[bit_sel] = 1'b1;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign free_next = dec ? (r_free - FREE_W'(1)) :
                       inc ? (r_free + FREE_W'(1)) : r_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_block <= i_block;
        end
        if (i_cmd.rd) begin
            r_rd_raw <= r_mem[rd_addr];
            r_rd_vld <= r_row_vld[rd_addr];
            r_widx   <= rd_addr;
            r_none   <= &r_full;
        end
        if (i_cmd.upd && wr_en) begin
            r_mem[r_widx] <= new_word;
        end
        if (i_cmd.upd) begin
            r_out_data <= {{(M_TDATA_W - FREE_OUT_W - 1 - BLK_W){1'b0}},
                           FREE_OUT_W'(free_next), status, granted};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld   <= '0;
            r_full      <= '0;
            r_free      <= FREE_W'(USABLE_BLOCKS);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.upd) begin
                r_free <= free_next;
                if (wr_en) begin
                    r_row_vld[r_widx] <= 1'b1;
                    r_full[r_widx]    <= &new_word;
                end
            end
            if (i_cmd.upd) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit allocator over a one-bit-per-block used map with free count.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive as beats on the s_axis channel: tuser carries the kind
//   (allocate, release, mark used), tdata carries the block number. Every
//   request answers with exactly one beat on m_axis: granted block, status
//   (full on a failed allocate) and the free count after the request.
//   A request is registered, then its map word is read, updated and
//   written back through the single map memory port, and the result is
//   registered for m_axis. s_axis_tready is high only between requests.
//   Allocate picks the first word whose summary bit says not full, then the
//   lowest clear bit in that word.
//   Reset: all blocks free, free count at the block total, no beat pending;
//   no clearing pass is needed.
//   Stall: a result waits in the output register while m_axis_tready is low;
//   the next request is read but not applied until that result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator
    import bba_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire [S_TDATA_W-1:0]  s_axis_tdata,   // [9:0] block, [15:10] zero
    input  wire [KIND_W-1:0]     s_axis_tuser,   // [1:0] kind
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // [9:0] granted_block, [10] status,
                                                 // [21:11] free_count, [23:22] zero
);

    t_cmd cmd;
    t_sts sts;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bba_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (s_axis_tuser),
        .i_block     (s_axis_tdata[BLK_W-1:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/bba_chk.sv =====
// ----------------------------------------------------------------------------
// bba_chk
// Port-level checks for the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_block_allocator_macros.svh"

module bba_chk
    import bba_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  s_axis_tvalid,
    input wire                  s_axis_tready,
    input wire [S_TDATA_W-1:0]  s_axis_tdata,
    input wire [KIND_W-1:0]     s_axis_tuser,
    input wire                  m_axis_tvalid,
    input wire                  m_axis_tready,
    input wire [M_TDATA_W-1:0]  m_axis_tdata
);

    logic [FREE_OUT_W-1:0] free_cnt;
    logic                  s_beat;

    assign free_cnt = m_axis_tdata[BLK_W+FREE_OUT_W:BLK_W+1];
    assign s_beat   = s_axis_tvalid && s_axis_tready;

    `BBA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `BBA_ASSERT_NEXT(a_busy_after_take, s_beat, !s_axis_tready)
    `BBA_ASSERT_NOW(a_full_reply, m_axis_tvalid && m_axis_tdata[BLK_W], m_axis_tdata[BLK_W-1:0] == '0 && free_cnt == '0)
    `BBA_ASSERT_NOW(a_free_bound, m_axis_tvalid, free_cnt <= FREE_OUT_W'(USABLE_BLOCKS))

endmodule

bind bitmap_block_allocator bba_chk u_bba_chk (.*);

`default_nettype wire
